/* hdl/rst_pkg.sv */
// ----------------------------------------------------------------------------
// rst_pkg
// shared types and constants for the request sequence tracker
// ----------------------------------------------------------------------------
package rst_pkg;

  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned IdW    = 48;
  localparam int unsigned StampW = 64;
  localparam int unsigned IncW   = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    StAccepted  = 3'd0,
    StDuplicate = 3'd1,
    StConflict  = 3'd2,
    StServiced  = 3'd3,
    StBusy      = 3'd4,
    StInvalid   = 3'd5,
    StRemoved   = 3'd6,
    StUnknown   = 3'd7
  } status_e;

  typedef enum logic [0:0] {
    CfgIncrement  = 1'b0,
    CfgAccounting = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkClear,
    BkIdle,
    BkRead,
    BkDecide,
    BkAdvRead,
    BkAdvCheck,
    BkOut
  } bk_state_e;

  typedef struct packed {
    logic              func;
    logic              pkt_valid;
    logic [IdW-1:0]    id;
    logic [StampW-1:0] stamp;
  } item_t;

endpackage

/* hdl/request_sequence_tracker_core.sv */
// ----------------------------------------------------------------------------
// request_sequence_tracker_core
// tracks pending and completed requests keyed by sequence id
// ----------------------------------------------------------------------------
// usage
// - command channel: a beat is taken when start is high and busy is low;
//   busy rises only when the two-entry queue to the back end is full
// - result channel: result_valid_o strobes for one cycle per command beat,
//   with status_o, stored_timestamp_o and highest_serviced_o; the receiver
//   cannot stall, so results are never held back
// - config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
//   always ready; write only while the block is idle
// - steps: a beat passes the queue, then the back end states Idle, Read,
//   Decide and Out; a remove that records a completed id with accounting on
//   adds a final AdvRead/AdvCheck pass plus one such pass for each step that
//   the highest serviced id advances; the back end sequencer, with a single
//   read port on each table, takes a new item only after the last result
// - reset: a clearing pass over all TABLE_DEPTH slots empties both tables, beats
//   queue up meanwhile; highest serviced id is zero, increment is one and
//   accounting is enabled
// - table depth must be a power of two, the slot is the low id bits
// ----------------------------------------------------------------------------
module request_sequence_tracker_core
  import rst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic              packet_valid_i,
  input  logic [IdW-1:0]    seq_id_i,
  input  logic [StampW-1:0] req_timestamp_i,
  output logic              result_valid_o,
  output logic [2:0]        status_o,
  output logic [StampW-1:0] stored_timestamp_o,
  output logic [IdW-1:0]    highest_serviced_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [IncW-1:0]   cfg_data_i
);
  logic [IncW-1:0] inc_q;
  logic            acct_q;
  item_t           item, q_item;
  logic            q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= IncW'(1);
      acct_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgIncrement:  inc_q  <= cfg_data_i;
        CfgAccounting: acct_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item = '{func: func_i, pkt_valid: packet_valid_i,
                  id: seq_id_i, stamp: req_timestamp_i};

  rst_front u_front (
    .clk_i, .rst_ni,
    .start_i   (start),
    .item_i    (item),
    .busy_o    (busy),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  rst_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .inc_i       (inc_q),
    .acct_i      (acct_q),
    .res_valid_o (result_valid_o),
    .status_o    (status_o),
    .stamp_o     (stored_timestamp_o),
    .highest_o   (highest_serviced_o)
  );
endmodule

/* hdl/rst_front.sv */
// ----------------------------------------------------------------------------
// rst_front
// accepts command beats and queues them for the back end
// ----------------------------------------------------------------------------
module rst_front
  import rst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  output logic  busy_o,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  logic  q_pop_i
);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push;

  assign busy_o    = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end
endmodule

/* hdl/rst_back.sv */
// ----------------------------------------------------------------------------
// rst_back
// executes tracker items against the pending and completed tables
// ----------------------------------------------------------------------------
module rst_back
  import rst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  input  logic [IncW-1:0]   inc_i,
  input  logic              acct_i,
  output logic              res_valid_o,
  output logic [2:0]        status_o,
  output logic [StampW-1:0] stamp_o,
  output logic [IdW-1:0]    highest_o
);
  localparam int unsigned SlotW = $clog2(TABLE_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_DEPTH - 1);

  // id words carry their valid flag in the top bit
  logic [IdW:0]      pid_mem [TABLE_DEPTH];
  logic [StampW-1:0] pst_mem [TABLE_DEPTH];
  logic [IdW:0]      did_mem [TABLE_DEPTH];

  bk_state_e st_q, st_d;
  item_t             it_q;
  logic [IdW:0]      pid_rd_q, did_rd_q;
  logic [IdW-1:0]    hs_q;
  logic [StampW-1:0] pst_rd_q;
  logic [IdW:0]      next_q;
  logic [2:0]        status_q;
  logic [StampW-1:0] stamp_q;
  logic [SlotW-1:0]  clr_q;

  logic [SlotW-1:0] slot, nslot, rslot;
  logic             pend_hit, done_hit, pv_s, dv_s;
  logic             ld_item, ld_out, adv_go, adv_ok, clr_en;
  logic [2:0]       status_d;
  logic [StampW-1:0] stamp_d;
  logic             p_set, p_clr, d_set;

  assign slot  = it_q.id[SlotW-1:0];
  assign nslot = next_q[SlotW-1:0];
  assign rslot = (st_q == BkAdvRead) ? nslot : slot;
  assign pv_s  = pid_rd_q[IdW];
  assign dv_s  = did_rd_q[IdW];
  assign pend_hit = pv_s && (pid_rd_q[IdW-1:0] == it_q.id);
  assign done_hit = dv_s && (did_rd_q[IdW-1:0] == it_q.id);
  assign adv_ok = !next_q[IdW] && did_rd_q[IdW] &&
                  (did_rd_q[IdW-1:0] == next_q[IdW-1:0]);

  // decision for the item under work
  always_comb begin
    status_d = StAccepted;
    stamp_d  = '0;
    p_set = 1'b0;
    p_clr = 1'b0;
    d_set = 1'b0;
    if (!it_q.func) begin
      if (!it_q.pkt_valid) begin
        status_d = StInvalid;
        if (pend_hit) stamp_d = pst_rd_q;
      end else if (pend_hit) begin
        stamp_d  = pst_rd_q;
        status_d = (pst_rd_q != it_q.stamp) ? StConflict : StDuplicate;
      end else if (it_q.id <= hs_q || done_hit) begin
        status_d = StServiced;
      end else if (pv_s) begin
        status_d = StBusy;
      end else begin
        p_set    = 1'b1;
        stamp_d  = it_q.stamp;
        status_d = StAccepted;
      end
    end else begin
      p_clr    = pend_hit;
      status_d = pend_hit ? StRemoved : StUnknown;
      if (it_q.id > hs_q) begin
        if (dv_s && did_rd_q[IdW-1:0] != it_q.id) status_d = StBusy;
        else d_set = 1'b1;
      end
    end
  end

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    ld_item = 1'b0;
    ld_out  = 1'b0;
    adv_go  = 1'b0;
    clr_en  = 1'b0;
    unique case (st_q)
      // one slot of each table cleared per cycle after reset
      BkClear: begin
        clr_en = 1'b1;
        if (clr_q == LastSlot) st_d = BkIdle;
      end
      BkIdle: if (q_valid_i) begin
        q_pop_o = 1'b1;
        ld_item = 1'b1;
        st_d    = BkRead;
      end
      BkRead:   st_d = BkDecide;
      BkDecide: begin
        ld_out = 1'b1;
        st_d   = (d_set && acct_i) ? BkAdvRead : BkOut;
      end
      BkAdvRead:  st_d = BkAdvCheck;
      BkAdvCheck: begin
        if (acct_i && adv_ok) begin
          adv_go = 1'b1;
          st_d   = BkAdvRead;
        end else begin
          st_d = BkOut;
        end
      end
      BkOut:   st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BkClear;
      clr_q <= '0;
      hs_q  <= '0;
    end else begin
      st_q <= st_d;
      if (clr_en) clr_q <= clr_q + 1'b1;
      if (adv_go) hs_q <= next_q[IdW-1:0];
    end
  end

  // payload and table ports
  always_ff @(posedge clk_i) begin
    if (ld_item) it_q <= q_item_i;
    pid_rd_q <= pid_mem[rslot];
    pst_rd_q <= pst_mem[rslot];
    did_rd_q <= did_mem[rslot];
    if (clr_en) begin
      pid_mem[clr_q] <= '0;
      did_mem[clr_q] <= '0;
    end
    if (ld_out) begin
      status_q <= status_d;
      stamp_q  <= stamp_d;
      if (p_set) begin
        pid_mem[slot] <= {1'b1, it_q.id};
        pst_mem[slot] <= it_q.stamp;
      end
      if (p_clr) pid_mem[slot] <= {1'b0, it_q.id};
      if (d_set) did_mem[slot] <= {1'b1, it_q.id};
    end
    if (adv_go) did_mem[nslot] <= {1'b0, next_q[IdW-1:0]};
    if (ld_out || adv_go) begin
      next_q <= {1'b0, (adv_go ? next_q[IdW-1:0] : hs_q)} + (IdW+1)'(inc_i);
    end
  end

  assign res_valid_o = (st_q == BkOut);
  assign status_o    = status_q;
  assign stamp_o     = stamp_q;
  assign highest_o   = hs_q;
endmodule
